// ----- hw/rtl/sfs_pkg.sv -----
// shared constants, codes and control structs for the sprite frame sequencer
package sfs_pkg;

   // field widths fixed by the interface
   localparam int REQ_TYPE_W    = 2;
   localparam int DELTA_W       = 24;
   localparam int TABLE_INDEX_W = 6;
   localparam int DURATION_W    = 24;
   localparam int FRAME_INDEX_W = 6;
   localparam int FRAME_COUNT_W = 7;
   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = 7;

   localparam int REQ_TDATA_W = 56;
   localparam int RSP_TDATA_W = 8;

   // parameter defaults
   localparam int DEFAULT_MAX_FRAMES = 64;
   localparam int DEFAULT_TIME_BITS  = 24;

   // request kinds
   localparam logic [REQ_TYPE_W-1:0] REQ_TICK    = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_WRITE   = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_RESTART = 2'd2;
   localparam logic [REQ_TYPE_W-1:0] REQ_STOP    = 2'd3;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_COUNT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOOP_ENABLE = 2'd1;

   typedef logic [FRAME_INDEX_W-1:0] out_frame_type;

   typedef struct packed {
      logic accept;
      logic tick_start;
      logic step;
      logic sum_clear;
      logic sum_step;
      logic rd_sweep;
      logic mod_step;
      logic mod_load;
      logic rsp_load;
   } sfs_cmd_type;

   typedef struct packed {
      logic tick_idle;
      logic count_zero;
      logic covers;
      logic wrap;
      logic loop_en;
      logic dur_zero;
      logic sweep_done;
      logic total_zero;
      logic mod_done;
   } sfs_sts_type;

endpackage

// ----- hw/rtl/sfs_datapath.sv -----
// datapath: duration table, frame and time state, cycle sum and remainder unit
module sfs_datapath #(
   parameter int MAX_FRAMES = sfs_pkg::DEFAULT_MAX_FRAMES,
   parameter int TIME_BITS  = sfs_pkg::DEFAULT_TIME_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wen,
   input  logic [sfs_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [sfs_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  logic [sfs_pkg::REQ_TYPE_W-1:0]       req_type,
   input  logic [sfs_pkg::DELTA_W-1:0]          delta_time,
   input  logic [sfs_pkg::TABLE_INDEX_W-1:0]    table_index,
   input  logic [sfs_pkg::DURATION_W-1:0]       duration_value,
   input  sfs_pkg::sfs_cmd_type                 cmd,
   output sfs_pkg::sfs_sts_type                 sts,
   output sfs_pkg::out_frame_type               frame_index,
   output logic                                 frame_valid,
   output logic                                 finished
);

   localparam int FB   = $clog2(MAX_FRAMES);
   localparam int CB   = $clog2(MAX_FRAMES + 1);
   localparam int ACCW = TIME_BITS + 1;
   localparam int SUMW = TIME_BITS + FB;
   localparam int CW   = (SUMW > ACCW + 1) ? SUMW : ACCW + 1;
   localparam int BB   = $clog2(ACCW);

   typedef logic [FB-1:0]        frame_type;
   typedef logic [CB-1:0]        cnt_type;
   typedef logic [TIME_BITS-1:0] time_type;
   typedef logic [ACCW-1:0]      acc_type;
   typedef logic [ACCW:0]        acc_ext_type;
   typedef logic [SUMW-1:0]      sum_type;
   typedef logic [CW-1:0]        cmp_type;
   typedef logic [BB-1:0]        bit_type;

   time_type table_mem [MAX_FRAMES];
   time_type rd_data_ff;
   frame_type rd_addr;
   frame_type wr_addr;
   logic wr_en;

   logic [sfs_pkg::FRAME_COUNT_W-1:0] frame_count_ff, frame_count_in;
   logic loop_ff, loop_in;
   frame_type frame_ff, frame_in;
   acc_type acc_ff, acc_in;
   logic done_ff, done_in;
   logic playing_ff, playing_in;
   time_type delta_ff, delta_in;
   cnt_type sweep_ff, sweep_in;
   sum_type sum_ff, sum_in;
   logic zero_ff, zero_in;
   acc_type rem_ff, rem_in;
   bit_type bit_ff, bit_in;
   sfs_pkg::out_frame_type out_frame_ff, out_frame_in;
   logic out_valid_ff, out_valid_in;
   logic out_fin_ff, out_fin_in;

   cnt_type act_count;
   cnt_type frame_ext;
   cnt_type next_ext;
   logic stale;
   logic tick_idle;
   acc_type base_acc;
   acc_ext_type add_acc;
   acc_type sat_acc;
   acc_type dur_ext;
   acc_type sub_acc;
   logic [ACCW:0] shifted;
   cmp_type shifted_cmp;
   cmp_type total_cmp;
   cmp_type diff_cmp;

   // frame count clamps to the table depth
   always_comb begin
      if (int'(frame_count_ff) > MAX_FRAMES) begin
         act_count = cnt_type'(MAX_FRAMES);
      end else begin
         act_count = cnt_type'(frame_count_ff);
      end
   end

   assign frame_ext = cnt_type'(frame_ff);
   assign next_ext  = frame_ext + cnt_type'(1);
   assign stale     = frame_ext >= act_count;
   assign tick_idle = !playing_ff || done_ff;

   // saturating add of the elapsed time
   assign base_acc = stale ? '0 : acc_ff;
   assign add_acc  = acc_ext_type'(base_acc) + acc_ext_type'(delta_ff);
   assign sat_acc  = add_acc[ACCW] ? '1 : add_acc[ACCW-1:0];

   assign dur_ext = acc_type'(rd_data_ff);
   assign sub_acc = acc_ff - dur_ext;

   // one restoring remainder step
   assign shifted     = {rem_ff, acc_ff[ACCW-1]};
   assign shifted_cmp = cmp_type'(shifted);
   assign total_cmp   = cmp_type'(sum_ff);
   assign diff_cmp    = shifted_cmp - total_cmp;

   assign sts.tick_idle  = tick_idle;
   assign sts.count_zero = (act_count == '0);
   assign sts.covers     = acc_ff >= dur_ext;
   assign sts.wrap       = next_ext >= act_count;
   assign sts.loop_en    = loop_ff;
   assign sts.dur_zero   = (rd_data_ff == '0);
   assign sts.sweep_done = (sweep_ff == act_count);
   assign sts.total_zero = zero_ff;
   assign sts.mod_done   = (bit_ff == bit_type'(ACCW - 1));

   assign wr_en   = cmd.accept && (req_type == sfs_pkg::REQ_WRITE)
                    && (int'(table_index) < MAX_FRAMES);
   assign wr_addr = frame_type'(table_index);
   assign rd_addr = cmd.rd_sweep ? sweep_ff[FB-1:0] : frame_in;

   always_comb begin
      frame_count_in = frame_count_ff;
      loop_in        = loop_ff;
      frame_in       = frame_ff;
      acc_in         = acc_ff;
      done_in        = done_ff;
      playing_in     = playing_ff;
      delta_in       = delta_ff;
      sweep_in       = sweep_ff;
      sum_in         = sum_ff;
      zero_in        = zero_ff;
      rem_in         = rem_ff;
      bit_in         = bit_ff;
      out_frame_in   = out_frame_ff;
      out_valid_in   = out_valid_ff;
      out_fin_in     = out_fin_ff;

      if (csr_wen) begin
         if (csr_index == sfs_pkg::CSR_FRAME_COUNT) begin
            frame_count_in = csr_wdata;
         end else if (csr_index == sfs_pkg::CSR_LOOP_ENABLE) begin
            loop_in = csr_wdata[0];
         end
      end

      if (cmd.accept) begin
         unique case (req_type)
            sfs_pkg::REQ_TICK: begin
               delta_in = time_type'(delta_time);
            end
            sfs_pkg::REQ_WRITE: begin
            end
            sfs_pkg::REQ_RESTART: begin
               playing_in = 1'b1;
               frame_in   = '0;
               acc_in     = '0;
               done_in    = 1'b0;
            end
            sfs_pkg::REQ_STOP: begin
               playing_in = 1'b0;
               frame_in   = '0;
               acc_in     = '0;
               done_in    = 1'b1;
            end
            default: begin
            end
         endcase
      end

      if (cmd.tick_start && !tick_idle) begin
         if (act_count == '0) begin
            done_in = 1'b1;
         end else begin
            frame_in = stale ? '0 : frame_ff;
            acc_in   = sat_acc;
         end
      end

      if (cmd.step) begin
         acc_in = sub_acc;
         if (next_ext < act_count) begin
            frame_in = frame_type'(next_ext);
         end else if (loop_ff) begin
            frame_in = '0;
         end else begin
            frame_in = frame_type'(act_count - cnt_type'(1));
            done_in  = 1'b1;
            acc_in   = '0;
         end
      end

      if (cmd.sum_clear) begin
         sweep_in = '0;
         sum_in   = '0;
         zero_in  = 1'b0;
         rem_in   = '0;
         bit_in   = '0;
      end

      // data arrives in the cycle after its address
      if (cmd.sum_step) begin
         sweep_in = sweep_ff + cnt_type'(1);
         if (sweep_ff != '0) begin
            sum_in  = sum_ff + sum_type'(rd_data_ff);
            zero_in = zero_ff || (rd_data_ff == '0);
         end
      end

      if (cmd.mod_step) begin
         acc_in = acc_ff << 1;
         bit_in = bit_ff + bit_type'(1);
         if (shifted_cmp >= total_cmp) begin
            rem_in = acc_type'(diff_cmp);
         end else begin
            rem_in = acc_type'(shifted);
         end
      end

      if (cmd.mod_load) begin
         acc_in = rem_ff;
      end

      if (cmd.rsp_load) begin
         out_frame_in = sfs_pkg::out_frame_type'(frame_ff);
         out_valid_in = playing_ff && (frame_ext < act_count);
         out_fin_in   = done_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[wr_addr] <= time_type'(duration_value);
      end
      rd_data_ff <= table_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_count_ff <= '0;
         loop_ff        <= 1'b0;
         frame_ff       <= '0;
         acc_ff         <= '0;
         done_ff        <= 1'b0;
         playing_ff     <= 1'b0;
         sweep_ff       <= '0;
         bit_ff         <= '0;
      end else begin
         frame_count_ff <= frame_count_in;
         loop_ff        <= loop_in;
         frame_ff       <= frame_in;
         acc_ff         <= acc_in;
         done_ff        <= done_in;
         playing_ff     <= playing_in;
         sweep_ff       <= sweep_in;
         bit_ff         <= bit_in;
      end
   end

   always_ff @(posedge clock) begin
      delta_ff     <= delta_in;
      sum_ff       <= sum_in;
      zero_ff      <= zero_in;
      rem_ff       <= rem_in;
      out_frame_ff <= out_frame_in;
      out_valid_ff <= out_valid_in;
      out_fin_ff   <= out_fin_in;
   end

   assign frame_index = out_frame_ff;
   assign frame_valid = out_valid_ff;
   assign finished    = out_fin_ff;

   // a consumed frame always leaves the index inside the animation
   a_step_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.step |=> (frame_ext < act_count))
      else $error("frame index out of range after a step");

   // the remainder unit leaves less than one full cycle of time
   a_mod_below_total: assert property (@(posedge clock) disable iff (reset)
      cmd.mod_load |=> (cmp_type'(acc_ff) < cmp_type'(sum_ff)))
      else $error("accumulator not reduced below cycle total");

endmodule

// ----- hw/rtl/sfs_controller.sv -----
// controller: state machine sequencing ticks, cycle sum, remainder and result
module sfs_controller (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [sfs_pkg::REQ_TYPE_W-1:0] req_type,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output sfs_pkg::sfs_cmd_type           cmd,
   input  sfs_pkg::sfs_sts_type           sts
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_TICK   = 3'd1;
   localparam logic [2:0] S_STEP   = 3'd2;
   localparam logic [2:0] S_SUM    = 3'd3;
   localparam logic [2:0] S_MOD    = 3'd4;
   localparam logic [2:0] S_MODEND = 3'd5;
   localparam logic [2:0] S_RELOAD = 3'd6;
   localparam logic [2:0] S_OUT    = 3'd7;

   logic [2:0] state_ff, state_in;
   logic stepped_ff, stepped_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      stepped_in   = stepped_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = (req_type == sfs_pkg::REQ_TICK) ? S_TICK : S_OUT;
            end
         end
         S_TICK: begin
            cmd.tick_start = 1'b1;
            stepped_in     = 1'b0;
            if (sts.tick_idle || sts.count_zero) begin
               state_in = S_OUT;
            end else begin
               state_in = S_STEP;
            end
         end
         S_STEP: begin
            // in loop mode a zero-length frame reached by stepping ends the tick
            if (stepped_ff && sts.loop_en && sts.dur_zero) begin
               state_in = S_OUT;
            end else if (!sts.covers) begin
               state_in = S_OUT;
            end else begin
               cmd.step   = 1'b1;
               stepped_in = 1'b1;
               if (sts.wrap) begin
                  if (sts.loop_en) begin
                     cmd.sum_clear = 1'b1;
                     state_in      = S_SUM;
                  end else begin
                     state_in = S_OUT;
                  end
               end
            end
         end
         S_SUM: begin
            cmd.sum_step = 1'b1;
            cmd.rd_sweep = 1'b1;
            if (sts.sweep_done) begin
               state_in = S_MOD;
            end
         end
         S_MOD: begin
            if (sts.total_zero) begin
               state_in = S_RELOAD;
            end else begin
               cmd.mod_step = 1'b1;
               if (sts.mod_done) begin
                  state_in = S_MODEND;
               end
            end
         end
         S_MODEND: begin
            cmd.mod_load = 1'b1;
            state_in     = S_STEP;
         end
         S_RELOAD: begin
            state_in = S_STEP;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         stepped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         stepped_ff   <= stepped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   // a sweep starts only on a looping wrap of a consumed frame
   a_sum_on_wrap: assert property (@(posedge clock) disable iff (reset)
      cmd.sum_clear |-> (sts.loop_en && sts.wrap && sts.covers && cmd.step))
      else $error("cycle sum started without a looping wrap");

   // an idle or empty tick goes straight to the result
   a_idle_tick: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_TICK && (sts.tick_idle || sts.count_zero)) |=> (state_ff == S_OUT))
      else $error("idle tick did not return a result");

endmodule

// ----- hw/rtl/sprite_frame_sequencer.sv -----
// top level of the sprite animation frame sequencer
// frame sequencer for sprite animation: write words load per-frame durations
// into a table, a tick word adds elapsed time and the block steps through
// frames while the accumulated time covers the current frame, wrapping when
// looping or holding the last frame and raising finished otherwise; restart
// and stop words control playback. every accepted word returns one result
// word. write, restart and stop words go straight to the result stage, and a
// tick does too when playback is idle or the animation is empty; otherwise it
// steps through the consumed frames, reading each frame's duration from the
// table memory one address per cycle, and ends with a final compare, which is
// skipped when a non-looping pass runs off the end. a looping wrap adds a
// sweep over the table to sum one cycle of durations, then a pass through the
// bit-serial remainder unit when none is zero, after which less than one cycle
// of frames remains; the remainder unit is skipped when a duration is zero. a
// new word is accepted once the previous one is handed to the result
// register. the duration table needs no clearing pass: entries read before
// they are written give undefined durations
module sprite_frame_sequencer #(
   parameter int MAX_FRAMES = sfs_pkg::DEFAULT_MAX_FRAMES,
   parameter int TIME_BITS  = sfs_pkg::DEFAULT_TIME_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   // configuration write port
   input  logic                               csr_wen,
   input  logic [sfs_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [sfs_pkg::CSR_DATA_W-1:0]     csr_wdata,
   // request stream
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // delta_time [23:0], table_index [29:24], duration_value [53:30], zero pad
   input  logic [sfs_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // req_type [1:0]
   input  logic [sfs_pkg::REQ_TYPE_W-1:0]     req_tuser,
   // result stream
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // frame_index [5:0], frame_valid [6], finished [7]
   output logic [sfs_pkg::RSP_TDATA_W-1:0]    rsp_tdata
);

   localparam int TI_LO  = sfs_pkg::DELTA_W;
   localparam int DUR_LO = sfs_pkg::DELTA_W + sfs_pkg::TABLE_INDEX_W;

   sfs_pkg::sfs_cmd_type cmd;
   sfs_pkg::sfs_sts_type sts;

   // unpacked request fields
   logic [sfs_pkg::DELTA_W-1:0]       delta_time;
   logic [sfs_pkg::TABLE_INDEX_W-1:0] table_index;
   logic [sfs_pkg::DURATION_W-1:0]    duration_value;

   // result fields from the output register
   sfs_pkg::out_frame_type frame_index;
   logic frame_valid;
   logic finished;

   assign delta_time     = req_tdata[sfs_pkg::DELTA_W-1:0];
   assign table_index    = req_tdata[TI_LO +: sfs_pkg::TABLE_INDEX_W];
   assign duration_value = req_tdata[DUR_LO +: sfs_pkg::DURATION_W];

   assign rsp_tdata = {finished, frame_valid, frame_index};

   // sequencing of items, sweeps and result handoff
   sfs_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_type   (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   // table memory, playback state, cycle sum and remainder
   sfs_datapath #(
      .MAX_FRAMES (MAX_FRAMES),
      .TIME_BITS  (TIME_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_wen        (csr_wen),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_type       (req_tuser),
      .delta_time     (delta_time),
      .table_index    (table_index),
      .duration_value (duration_value),
      .cmd            (cmd),
      .sts            (sts),
      .frame_index    (frame_index),
      .frame_valid    (frame_valid),
      .finished       (finished)
   );

endmodule

// ----- test/sprite_frame_sequencer_test.sv -----
// self-checking testbench for the sprite frame sequencer: directed and random request words
module sprite_frame_sequencer_test;
   import sfs_pkg::*;

   // register slots the block does not implement, written to show they do nothing
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_3 = 2'd3;

   localparam int FRAMES = DEFAULT_MAX_FRAMES;
   // accumulator is one bit wider than a duration and saturates
   localparam logic [DELTA_W:0] ACC_LIMIT = '1;
   localparam logic [DELTA_W-1:0] TIME_MAX = '1;

   // result word layout, lowest field last
   typedef struct packed {
      logic                     finished;
      logic                     frame_valid;
      logic [FRAME_INDEX_W-1:0] frame_index;
   } frame_status_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_wen;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   logic req_tvalid;
   logic req_tready;
   // delta_time [23:0], table_index [29:24], duration_value [53:30], zero pad
   logic [REQ_TDATA_W-1:0] req_tdata;
   // req_type [1:0]
   logic [REQ_TYPE_W-1:0] req_tuser;
   logic rsp_tvalid;
   logic rsp_tready;
   // frame_index [5:0], frame_valid [6], finished [7]
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   sprite_frame_sequencer uut (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #10 clock = ~clock;

   // shadow copy of the sequencer state
   logic [DURATION_W-1:0] frame_time [FRAMES];
   logic [FRAME_INDEX_W-1:0] shown_frame = '0;
   logic [DELTA_W:0] time_banked = '0;
   logic done_seen = 1'b0;
   logic playing_now = 1'b0;
   logic [FRAME_COUNT_W-1:0] count_reg = '0;
   logic loop_reg = 1'b0;

   // table entries already written, so ticks never read an unwritten one
   bit loaded [FRAMES];

   frame_status_type expected_status [$];
   int mismatch_count = 0;

   // idling controls: 1 in N chance of a burst, 0 means never
   int gap_odds = 4;
   int stall_odds = 5;
   // long receiver hold-off, counted down by the result sink
   int hold_cycles = 0;

   // frame count as the block uses it: values above the table size act as the table size
   function automatic logic [FRAME_COUNT_W-1:0] active_span();
      return (count_reg > FRAMES) ? FRAME_COUNT_W'(FRAMES) : count_reg;
   endfunction

   // apply one request word to the shadow state and return the status it leaves
   function automatic frame_status_type advance_sequencer(
                                                       input logic [REQ_TYPE_W-1:0] kind,
                                                       input logic [DELTA_W-1:0] delta,
                                                       input logic [TABLE_INDEX_W-1:0] index,
                                                       input logic [DURATION_W-1:0] duration);
      frame_status_type status;
      logic [FRAME_COUNT_W-1:0] span;
      logic [FRAME_COUNT_W-1:0] pos;
      logic [DELTA_W+1:0] sum;
      logic [DURATION_W-1:0] dur;
      logic [31:0] total;
      span = active_span();
      case (kind)
         REQ_TICK: begin
            // idle tick: not playing or already finished
            if (playing_now && !done_seen) begin
               if (span == 0) begin
                  // empty animation finishes at once
                  done_seen = 1'b1;
               end else begin
                  pos = {1'b0, shown_frame};
                  // stale index left over from a larger frame count
                  if (pos >= span) begin
                     pos = '0;
                     time_banked = '0;
                  end
                  sum = time_banked + delta;
                  time_banked = (sum > ACC_LIMIT) ? ACC_LIMIT : sum[DELTA_W:0];
                  dur = frame_time[pos[FRAME_INDEX_W-1:0]];
                  while (time_banked >= dur) begin
                     time_banked = time_banked - dur;
                     pos = pos + 1'b1;
                     if (pos >= span) begin
                        if (loop_reg) begin
                           // whole cycles only shrink the accumulator, unless a zero frame
                           total = '0;
                           for (int i = 0; i < span; i++) begin
                              if (frame_time[i] == 0) begin
                                 total = '0;
                                 break;
                              end
                              total = total + frame_time[i];
                           end
                           pos = '0;
                           if (total != 0) time_banked = (DELTA_W+1)'(time_banked % total);
                        end else begin
                           // hold the last frame and finish
                           pos = span - 1'b1;
                           done_seen = 1'b1;
                           time_banked = '0;
                           break;
                        end
                     end
                     dur = frame_time[pos[FRAME_INDEX_W-1:0]];
                     // zero-length frame ends the tick when looping
                     if (dur == 0 && loop_reg) break;
                  end
                  shown_frame = pos[FRAME_INDEX_W-1:0];
               end
            end
         end
         REQ_WRITE: frame_time[index] = duration;
         REQ_RESTART: begin
            playing_now = 1'b1;
            shown_frame = '0;
            time_banked = '0;
            done_seen = 1'b0;
         end
         REQ_STOP: begin
            playing_now = 1'b0;
            shown_frame = '0;
            time_banked = '0;
            done_seen = 1'b1;
         end
      endcase
      status.frame_index = shown_frame;
      status.frame_valid = playing_now && ({1'b0, shown_frame} < span);
      status.finished = done_seen;
      return status;
   endfunction

   // mostly short frames, some zero, some huge
   function automatic logic [DURATION_W-1:0] pick_duration();
      int r;
      r = $urandom_range(0, 99);
      if (r < 8) return '0;
      if (r < 10) return TIME_MAX;
      if (r < 18) return DURATION_W'($urandom);
      return DURATION_W'($urandom_range(1, 300));
   endfunction

   function automatic logic [DELTA_W-1:0] pick_delta();
      int r;
      r = $urandom_range(0, 99);
      if (r < 4) return '0;
      if (r < 8) return TIME_MAX;
      if (r < 18) return DELTA_W'($urandom);
      return DELTA_W'($urandom_range(0, 600));
   endfunction

   // offer one request word, with an optional idle burst first, and predict its result
   task automatic send_word(input logic [REQ_TYPE_W-1:0] kind,
                            input logic [DELTA_W-1:0] delta,
                            input logic [TABLE_INDEX_W-1:0] index,
                            input logic [DURATION_W-1:0] duration);
      @(negedge clock);
      if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {2'b00, duration, index, delta};
      // handshake is judged on the values seen just before the edge
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (kind == REQ_WRITE) loaded[index] = 1'b1;
      expected_status.push_back(advance_sequencer(kind, delta, index, duration));
   endtask

   // unused fields of a word carry random bits
   task automatic send_tick(input logic [DELTA_W-1:0] delta);
      send_word(REQ_TICK, delta, TABLE_INDEX_W'($urandom), DURATION_W'($urandom));
   endtask

   task automatic send_write(input logic [TABLE_INDEX_W-1:0] index,
                             input logic [DURATION_W-1:0] duration);
      send_word(REQ_WRITE, DELTA_W'($urandom), index, duration);
   endtask

   task automatic send_control(input logic [REQ_TYPE_W-1:0] kind);
      send_word(kind, DELTA_W'($urandom), TABLE_INDEX_W'($urandom), DURATION_W'($urandom));
   endtask

   // drop valid and let every outstanding result come back
   task automatic wait_for_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_status.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // register write, only while the block is idle
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_wen <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_wen <= 1'b0;
      case (index)
         CSR_FRAME_COUNT: count_reg = value;
         CSR_LOOP_ENABLE: loop_reg = value[0];
         default: ;
      endcase
   endtask

   // new animation settings, then fill any table entry the ticks could reach
   task automatic set_animation(input int count, input logic loop_on);
      int span;
      wait_for_results();
      write_csr(CSR_FRAME_COUNT, CSR_DATA_W'(count));
      write_csr(CSR_LOOP_ENABLE, {(CSR_DATA_W-1)'($urandom_range(0, 63)), loop_on});
      if ($urandom_range(0, 2) == 0)
         write_csr($urandom_range(0, 1) ? CSR_SPARE_2 : CSR_SPARE_3, CSR_DATA_W'($urandom));
      span = (count > FRAMES) ? FRAMES : count;
      for (int i = 0; i < span; i++)
         if (!loaded[i]) send_write(TABLE_INDEX_W'(i), pick_duration());
   endtask

   // well-formed playback traffic with a little noise mixed in
   task automatic random_word();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) send_tick(pick_delta());
      else if (r < 80) send_write(TABLE_INDEX_W'($urandom), pick_duration());
      else if (r < 88) send_control(REQ_RESTART);
      else if (r < 93) send_control(REQ_STOP);
      else send_word(REQ_TYPE_W'($urandom), DELTA_W'($urandom), TABLE_INDEX_W'($urandom),
                     DURATION_W'($urandom));
   endtask

   // ticks while stopped, then with no frames at all
   task automatic test_idle_and_empty();
      send_tick(pick_delta());
      send_control(REQ_RESTART);
      send_tick(TIME_MAX);
      send_tick('0);
      send_control(REQ_STOP);
      send_tick(DELTA_W'(5));
   endtask

   // one non-looping pass over four frames, one of them zero length
   task automatic test_single_pass();
      wait_for_results();
      write_csr(CSR_FRAME_COUNT, 7'd4);
      write_csr(CSR_LOOP_ENABLE, 7'd0);
      send_write(TABLE_INDEX_W'(0), DURATION_W'(3));
      send_write(TABLE_INDEX_W'(1), '0);
      send_write(TABLE_INDEX_W'(2), DURATION_W'(5));
      send_write(TABLE_INDEX_W'(3), TIME_MAX);
      send_write(TABLE_INDEX_W'(FRAMES - 1), '0);
      send_control(REQ_RESTART);
      send_tick('0);
      send_tick(DELTA_W'(3));
      send_tick(TIME_MAX);
      // runs off the end, holds frame 3 and finishes
      send_tick(DELTA_W'(10));
      send_tick(DELTA_W'(1));
   endtask

   // looping over a zero frame keeps the leftover time, so big ticks saturate it
   task automatic test_loop_saturation();
      wait_for_results();
      write_csr(CSR_FRAME_COUNT, 7'd2);
      write_csr(CSR_LOOP_ENABLE, 7'd1);
      send_write(TABLE_INDEX_W'(0), DURATION_W'(1));
      send_write(TABLE_INDEX_W'(1), '0);
      send_control(REQ_RESTART);
      repeat (4) send_tick(TIME_MAX);
   endtask

   // shrink the frame count under the current frame
   task automatic test_stale_index();
      wait_for_results();
      write_csr(CSR_FRAME_COUNT, 7'd4);
      write_csr(CSR_SPARE_3, '1);
      send_control(REQ_RESTART);
      send_tick(DELTA_W'(8));
      send_tick('0);
      wait_for_results();
      write_csr(CSR_FRAME_COUNT, 7'd2);
      write_csr(CSR_SPARE_2, '0);
      send_tick(DELTA_W'(1));
   endtask

   // receiver holds off while words keep coming, so the block backs up
   task automatic test_backpressure();
      set_animation(16, 1'b1);
      send_control(REQ_RESTART);
      hold_cycles = 200;
      repeat (20) send_tick(pick_delta());
   endtask

   // phases over the extremes of both registers, then a few random settings
   task automatic test_random_phases();
      int plan_count [8] = '{1, 64, 127, 2, 100, 0, 5, 33};
      bit plan_loop [8] = '{0, 1, 0, 1, 1, 0, 1, 0};
      int count;
      logic loop_on;
      for (int p = 0; p < 12; p++) begin
         if (p < 8) begin
            count = plan_count[p];
            loop_on = plan_loop[p];
         end else begin
            count = $urandom_range(0, 127);
            loop_on = 1'($urandom_range(0, 1));
         end
         // every third phase runs with no idling on either side
         gap_odds = (p % 3 == 0) ? 0 : $urandom_range(2, 6);
         stall_odds = (p % 3 == 0) ? 0 : $urandom_range(2, 6);
         set_animation(count, loop_on);
         send_control(REQ_RESTART);
         repeat (24) random_word();
      end
   endtask

   // closing stretch at full rate on both sides
   task automatic test_quiet_finish();
      gap_odds = 0;
      stall_odds = 0;
      set_animation($urandom_range(1, FRAMES), 1'b1);
      send_control(REQ_RESTART);
      repeat (40) random_word();
   endtask

   initial begin
      reset = 1'b1;
      csr_wen = 1'b0;
      csr_index = CSR_FRAME_COUNT;
      csr_wdata = '0;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = REQ_TICK;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_idle_and_empty();
      test_single_pass();
      test_loop_saturation();
      test_stale_index();
      test_backpressure();
      test_random_phases();
      test_quiet_finish();
      wait_for_results();
      // catch any stray result word after the last one
      repeat (300) @(posedge clock);
      if (mismatch_count == 0 && expected_status.size() == 0) begin
         $display("sprite_frame_sequencer_test passed");
      end else begin
         $display("sprite_frame_sequencer_test failed");
      end
      $finish;
   end

   // result sink: random stall bursts plus the long hold-off on request
   initial begin : result_sink
      int stall_left;
      stall_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_tready <= 1'b0;
            hold_cycles--;
         end else if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
            rsp_tready <= 1'b0;
            stall_left = $urandom_range(0, 12);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // compare every accepted result word with the oldest prediction
   always @(posedge clock) begin : result_check
      frame_status_type seen;
      frame_status_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen = rsp_tdata;
         if (expected_status.size() == 0) begin
            mismatch_count++;
            $display("%0t: expected no result word, got %h", $time, rsp_tdata);
         end else begin
            want = expected_status.pop_front();
            if (seen !== want) begin
               mismatch_count++;
               // fields shown as frame_index/frame_valid/finished
               $display("%0t: expected %0d/%b/%b got %0d/%b/%b", $time,
                        want.frame_index, want.frame_valid, want.finished,
                        seen.frame_index, seen.frame_valid, seen.finished);
            end
         end
      end
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #40000000;
      $display("sprite_frame_sequencer_test failed");
      $finish;
   end

endmodule

// ----- files.f -----
hw/rtl/sfs_pkg.sv
hw/rtl/sfs_datapath.sv
hw/rtl/sfs_controller.sv
hw/rtl/sprite_frame_sequencer.sv
test/sprite_frame_sequencer_test.sv
